// ----- hw/rtl/stsp_pkg.sv -----
// Shared constants, types and constant tables for the step-time profile block.
`timescale 1ns / 1ps
`default_nettype none
package stsp_pkg;

    // Field and datapath widths
    localparam int STEP_W   = 13;
    localparam int TIME_W   = 24;
    localparam int LEN_W    = 12;
    localparam int FLOW_W   = 7;
    localparam int VOL_W    = 10;
    localparam int STOP_W   = 11;
    localparam int ROM_AW   = 11;
    localparam int ROM_DEPTH = 2048;
    localparam int POW_W    = 21;
    localparam int RAMP_W   = 12;
    localparam int PROD_W   = 42;
    localparam int DIV_W    = 18;
    localparam int LIMIT_W  = 35;
    localparam int CPROD_W  = 36;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    // Profile constants
    localparam int STEP_BOUND = 4096;
    localparam logic [STEP_W-1:0]  ACC_STEPS  = 13'd192;
    localparam logic [STOP_W-1:0]  DEC_STEPS  = 11'd28;
    localparam logic [RAMP_W-1:0]  T_MIN_US   = 12'd240;
    localparam logic [TIME_W-1:0]  TIME_MAX   = 24'hFF_FFFF;
    localparam logic [POW_W-1:0]   FLOW_K_Q16 = 21'd1733068;
    localparam logic [24:0]        LIMIT_K    = 25'd19200000;  // 75000 * 256
    localparam logic [FLOW_W-1:0]  FLOW_RST   = 7'd60;
    localparam logic [VOL_W-1:0]   VOL_RST    = 10'd500;

    // Register index codes (byte address bit 2)
    localparam logic REG_FLOW = 1'b0;
    localparam logic REG_VOL  = 1'b1;

    // Stop-step search sequencer
    typedef enum logic [1:0] {
        SR_IDLE,
        SR_ADDR,
        SR_MUL,
        SR_CMP
    } t_srch_state;

    // Configuration-derived values handed to the datapath
    typedef struct packed {
        logic              ready;
        logic [STOP_W-1:0] stop;
        logic [LEN_W-1:0]  len;
        logic [FLOW_W-1:0] flow;
    } t_cfg;

    // One classified word in flight
    typedef struct packed {
        logic [ROM_AW-1:0] n_idx;
        logic              kill;
        logic              beyond;
        logic              last;
        logic              flw_sel;
        logic [RAMP_W-1:0] ramp;
    } t_item;

    typedef logic [POW_W-1:0]  t_pow_tab [ROM_DEPTH];
    typedef logic [RAMP_W-1:0] t_acc_tab [256];
    typedef logic [RAMP_W-1:0] t_dec_tab [32];

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // floor(sqrt(floor(num / den))): largest r with den * r * r <= num
    function automatic logic [RAMP_W-1:0] ramp_root(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [RAMP_W-1:0] r;
        logic [RAMP_W-1:0] c;
        logic [63:0]       sq;
        r = '0;
        for (int i = RAMP_W - 1; i >= 0; i--) begin
            c  = r | (RAMP_W'(1) << i);
            sq = 64'(c) * 64'(c);
            if (den * sq <= num) r = c;
        end
        return r;
    endfunction

    // n^1.1605 in Q8 for n = 0 .. ROM_DEPTH-1
    function automatic t_pow_tab build_pow();
        t_pow_tab    tab;
        logic [63:0] t [17];
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] lg;
        logic [63:0] m;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] e;
        t[0] = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) t[k] = isqrt64(t[k-1] << 30);
        for (int n = 0; n < ROM_DEPTH; n++) begin
            if (n == 0) begin
                tab[n] = '0;
            end else begin
                e = 0;
                for (int i = 0; i < 31; i++) begin
                    if ((64'(n) >> e) > 1) e = e + 1;
                end
                y = 64'(n) << (30 - e);
                frac = 0;
                for (int i = 0; i < 16; i++) begin
                    y = (y * y) >> 30;
                    frac = frac << 1;
                    if (y >= (64'd2 << 30)) begin
                        y = y >> 1;
                        frac = frac | 64'd1;
                    end
                end
                lg = (e << 16) | frac;
                m = (lg * 64'd76055) >> 16;
                q = m >> 16;
                f = m & 64'hFFFF;
                r = 64'd1 << 30;
                for (int k = 1; k <= 16; k++) begin
                    if (((f >> (16 - k)) & 64'd1) != 0) r = (r * t[k]) >> 30;
                end
                if (q > 30) q = 30;
                r = (r << q) >> 22;
                tab[n] = r[POW_W-1:0];
            end
        end
        return tab;
    endfunction

    // Acceleration ramp period per step, 240 at step 0 and past the ramp
    function automatic t_acc_tab build_acc();
        t_acc_tab    tab;
        for (int n = 0; n < 256; n++) begin
            if (n >= 1 && n <= 192) begin
                tab[n] = ramp_root(64'd100000000, 64'd9 * 64'(n));
            end else begin
                tab[n] = T_MIN_US;
            end
        end
        return tab;
    endfunction

    // Deceleration ramp period by distance to the stop step
    function automatic t_dec_tab build_dec();
        t_dec_tab    tab;
        for (int d = 0; d < 32; d++) begin
            if (d >= 1 && d <= 29) begin
                tab[d] = ramp_root(64'd5000000, 64'd3 * 64'(d));
            end else begin
                tab[d] = T_MIN_US;
            end
        end
        return tab;
    endfunction

    localparam t_acc_tab ACC_TAB = build_acc();
    localparam t_dec_tab DEC_TAB = build_dec();

endpackage
`default_nettype wire

// ----- hw/rtl/stepper_step_time_profile_core.sv -----
// Top level of the stepper step-time profile block.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one step number per word.
//   Output channel (o_out_valid / i_out_ready) returns one word per input: the
//   step period in us, the profile length, and last-step / beyond-profile flags.
//   Setpoints (flow at 0x0, volume at 0x4) are written over the APB port; the user
//   must write them only while the block is idle, which the block does not enforce.
// Pipeline and throughput:
//   A word passes the queue, the ROM read and flow scaling registers, the 18-stage
//   divide by the flow setpoint and the output register; one word per cycle is
//   sustained while the output is not held.
//   After reset and after every setpoint write, the stop-step search runs through
//   11 search bits, one ADDR/MUL/CMP round each on the search port of the power ROM;
//   o_in_ready is low during that time. Setpoints reset to 60 l/min and 500 ml.
// Stalls:
//   When i_out_ready is low while an output word is valid, the whole back pipeline
//   freezes; a 4-word queue keeps taking input until it fills, then o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module stepper_step_time_profile_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stsp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stsp_pkg::PDATA_W-1:0] pwdata,
    output logic      [stsp_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [stsp_pkg::STEP_W-1:0]  i_step_number,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [stsp_pkg::TIME_W-1:0]  o_step_time_us,
    output logic      [stsp_pkg::LEN_W-1:0]   o_profile_length,
    output logic                              o_last_step,
    output logic                              o_beyond_profile
);
    import stsp_pkg::*;

    t_cfg               cfg;
    t_item              q_item;
    logic               q_valid;
    logic               q_pop;
    logic               rom_a_en;
    logic [ROM_AW-1:0]  rom_a_addr;
    logic [POW_W-1:0]   rom_a_data;
    logic               rom_b_en;
    logic [ROM_AW-1:0]  rom_b_addr;
    logic [POW_W-1:0]   rom_b_data;

    stsp_pow_rom u_rom (
        .i_clk    (i_clk),
        .i_a_en   (rom_a_en),
        .i_a_addr (rom_a_addr),
        .o_a_data (rom_a_data),
        .i_b_en   (rom_b_en),
        .i_b_addr (rom_b_addr),
        .o_b_data (rom_b_data)
    );

    stsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_rom_addr (rom_a_addr),
        .o_rom_en   (rom_a_en),
        .i_rom_data (rom_a_data),
        .o_cfg      (cfg)
    );

    stsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_step_number (i_step_number),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    stsp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_rom_addr       (rom_b_addr),
        .o_rom_en         (rom_b_en),
        .i_rom_data       (rom_b_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_step_time_us   (o_step_time_us),
        .o_profile_length (o_profile_length),
        .o_last_step      (o_last_step),
        .o_beyond_profile (o_beyond_profile)
    );

    // a word is never both the last step and beyond the profile
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_last_step && o_beyond_profile))
        else $error("last_step and beyond_profile both set");

    // beyond-profile words carry no period
    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_beyond_profile) |-> (o_step_time_us == '0))
        else $error("beyond-profile word has nonzero period");

    // a real period never drops under the motor limit
    a_min_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_step_time_us != '0)) |->
            (o_step_time_us >= {{(TIME_W-RAMP_W){1'b0}}, T_MIN_US}))
        else $error("period below motor limit");

    // a setpoint write restarts the search and blocks input
    a_write_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> !o_in_ready)
        else $error("input taken while stop step is stale");
endmodule
`default_nettype wire

// ----- hw/rtl/stsp_pow_rom.sv -----
// Two-port registered-read ROM of n^1.1605 in Q8.
`timescale 1ns / 1ps
`default_nettype none
module stsp_pow_rom (
    input  wire logic                       i_clk,
    input  wire logic                       i_a_en,
    input  wire logic [stsp_pkg::ROM_AW-1:0] i_a_addr,
    output logic      [stsp_pkg::POW_W-1:0]  o_a_data,
    input  wire logic                       i_b_en,
    input  wire logic [stsp_pkg::ROM_AW-1:0] i_b_addr,
    output logic      [stsp_pkg::POW_W-1:0]  o_b_data
);
    import stsp_pkg::*;

    localparam t_pow_tab POW_TAB = build_pow();

    logic [POW_W-1:0] r_a_data;
    logic [POW_W-1:0] r_b_data;

    // port a: stop-step search
    always_ff @(posedge i_clk) begin
        if (i_a_en) r_a_data <= POW_TAB[i_a_addr];
    end

    // port b: datapath
    always_ff @(posedge i_clk) begin
        if (i_b_en) r_b_data <= POW_TAB[i_b_addr];
    end

    assign o_a_data = r_a_data;
    assign o_b_data = r_b_data;
endmodule
`default_nettype wire

// ----- hw/rtl/stsp_cfg.sv -----
// Setpoint registers, APB access and stop-step search sequencer.
`timescale 1ns / 1ps
`default_nettype none
module stsp_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stsp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stsp_pkg::PDATA_W-1:0] pwdata,
    output logic      [stsp_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output logic      [stsp_pkg::ROM_AW-1:0]  o_rom_addr,
    output logic                              o_rom_en,
    input  wire logic [stsp_pkg::POW_W-1:0]   i_rom_data,
    output stsp_pkg::t_cfg                    o_cfg
);
    import stsp_pkg::*;

    logic [FLOW_W-1:0]  r_flow;
    logic [VOL_W-1:0]   r_vol;
    logic [STOP_W-1:0]  r_lo;
    logic [STOP_W-1:0]  r_bit;
    logic [LIMIT_W-1:0] r_limit;
    logic [CPROD_W-1:0] r_prod;
    t_srch_state        r_state;
    t_srch_state        n_state;

    logic               wr_en;
    logic [STOP_W-1:0]  cand;
    logic [31:0]        cp;
    logic [STEP_W-1:0]  steps;
    logic [STEP_W-1:0]  len_raw;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cand   = r_lo | r_bit;

    // setpoint registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= FLOW_RST;
            r_vol  <= VOL_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FLOW: r_flow <= pwdata[FLOW_W-1:0];
                REG_VOL:  r_vol  <= pwdata[VOL_W-1:0];
                default:  ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_FLOW: prdata = {{(PDATA_W-FLOW_W){1'b0}}, r_flow};
            REG_VOL:  prdata = {{(PDATA_W-VOL_W){1'b0}}, r_vol};
            default:  prdata = '0;
        endcase
    end

    // search next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SR_IDLE: n_state = SR_IDLE;
            SR_ADDR: n_state = SR_MUL;
            SR_MUL:  n_state = SR_CMP;
            SR_CMP:  n_state = (r_bit == STOP_W'(1)) ? SR_IDLE : SR_ADDR;
            default: n_state = SR_IDLE;
        endcase
        if (wr_en) n_state = SR_ADDR;
    end

    // search outputs
    always_comb begin
        o_rom_en   = (r_state == SR_ADDR);
        o_rom_addr = cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= SR_ADDR;
        else          r_state <= n_state;
    end

    // binary search, one bit per ADDR/MUL/CMP round
    assign cp = {{(32-STOP_W){1'b0}}, cand} * {{(32-POW_W){1'b0}}, i_rom_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wr_en) begin
            r_lo  <= '0;
            r_bit <= STOP_W'(1) << (STOP_W - 1);
        end else if (r_state == SR_CMP) begin
            if (r_prod <= {1'b0, r_limit}) r_lo <= cand;
            r_bit <= r_bit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SR_ADDR) r_limit <= LIMIT_W'(r_vol) * LIMIT_W'(LIMIT_K);
        if (r_state == SR_MUL)  r_prod  <= {cp, 4'b0} + CPROD_W'(cp);
    end

    // profile length from the stop step
    assign steps   = (STEP_W'(r_lo) < STEP_W'(STEP_BOUND)) ? STEP_W'(r_lo)
                                                           : STEP_W'(STEP_BOUND);
    assign len_raw = (steps == '0) ? '0 : steps - 1'b1;

    always_comb begin
        o_cfg.ready = (r_state == SR_IDLE);
        o_cfg.stop  = r_lo;
        o_cfg.len   = LEN_W'(len_raw);
        o_cfg.flow  = r_flow;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/stsp_front.sv -----
// Front end: accepts step words, classifies them, looks up ramp terms, queues them.
`timescale 1ns / 1ps
`default_nettype none
module stsp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stsp_pkg::t_cfg              i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [stsp_pkg::STEP_W-1:0] i_step_number,
    output logic                             o_q_valid,
    output stsp_pkg::t_item                  o_q_item,
    input  wire logic                        i_q_pop
);
    import stsp_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;

    logic               push;
    logic [STEP_W-1:0]  stop_x;
    logic [STEP_W-1:0]  len_x;
    logic [STOP_W-1:0]  lowb;
    logic [STEP_W-1:0]  gap;
    logic               in_win;
    logic [RAMP_W-1:0]  acc;
    logic [RAMP_W-1:0]  dec;
    t_item              item;

    assign o_in_ready = (r_cnt != QCNT_W'(QDEPTH)) && i_cfg.ready;
    assign push       = i_in_valid && o_in_ready;

    // classify and pick up the ramp terms
    always_comb begin
        stop_x = {{(STEP_W-STOP_W){1'b0}}, i_cfg.stop};
        len_x  = {{(STEP_W-LEN_W){1'b0}}, i_cfg.len};
        lowb   = (i_cfg.stop > DEC_STEPS) ? i_cfg.stop - DEC_STEPS : '0;
        in_win = (i_step_number >= {{(STEP_W-STOP_W){1'b0}}, lowb}) &&
                 (i_step_number <= stop_x);
        gap    = stop_x + STEP_W'(1) - i_step_number;
        acc    = (i_step_number <= ACC_STEPS) ? ACC_TAB[i_step_number[7:0]] : T_MIN_US;
        dec    = in_win ? DEC_TAB[gap[4:0]] : T_MIN_US;

        item.n_idx   = i_step_number[ROM_AW-1:0];
        item.beyond  = (i_step_number != '0) && (i_step_number > len_x);
        item.kill    = (i_step_number == '0) || item.beyond;
        item.last    = !item.kill && (i_step_number == len_x);
        item.flw_sel = stop_x > i_step_number;
        item.ramp    = (acc > dec) ? acc : dec;
    end

    // word queue
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push)    r_wptr <= r_wptr + 1'b1;
            if (i_q_pop) r_rptr <= r_rptr + 1'b1;
            unique case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rptr];
endmodule
`default_nettype wire

// ----- hw/rtl/stsp_back.sv -----
// Back end: power lookup, flow scaling, pipelined divide by flow, max and output register.
`timescale 1ns / 1ps
`default_nettype none
module stsp_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire stsp_pkg::t_cfg               i_cfg,
    input  wire logic                         i_q_valid,
    input  wire stsp_pkg::t_item              i_q_item,
    output logic                              o_q_pop,
    output logic      [stsp_pkg::ROM_AW-1:0]  o_rom_addr,
    output logic                              o_rom_en,
    input  wire logic [stsp_pkg::POW_W-1:0]   i_rom_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [stsp_pkg::TIME_W-1:0]  o_step_time_us,
    output logic      [stsp_pkg::LEN_W-1:0]   o_profile_length,
    output logic                              o_last_step,
    output logic                              o_beyond_profile
);
    import stsp_pkg::*;

    logic               adv;
    logic               r_v1;
    t_item              r_it1;
    logic               r_v2;
    t_item              r_it2;
    logic [PROD_W-1:0]  r_prod;

    logic               r_dv  [DIV_W];
    t_item              r_dit [DIV_W];
    logic [FLOW_W-1:0]  r_drem[DIV_W];
    logic [DIV_W-1:0]   r_dx  [DIV_W];

    logic [FLOW_W-1:0]  src_rem[DIV_W];
    logic [DIV_W-1:0]   src_x  [DIV_W];
    logic [FLOW_W-1:0]  nxt_rem[DIV_W];
    logic [DIV_W-1:0]   nxt_x  [DIV_W];

    logic               r_ov;
    logic [TIME_W-1:0]  r_time;
    logic [LEN_W-1:0]   r_len;
    logic               r_last;
    logic               r_beyond;

    t_item              fin;
    logic [DIV_W-1:0]   quo;
    logic [TIME_W-1:0]  flw;
    logic [TIME_W-1:0]  ramp_x;
    logic [TIME_W-1:0]  tmax;

    // whole pipeline moves together unless the output word is held
    assign adv        = !r_ov || i_out_ready;
    assign o_q_pop    = adv && i_q_valid;
    assign o_rom_en   = adv;
    assign o_rom_addr = i_q_item.n_idx;

    // stage 1 (ROM read) and stage 2 (scale by flow constant)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it1  <= i_q_item;
            r_it2  <= r_it1;
            r_prod <= PROD_W'(i_rom_data) * PROD_W'(FLOW_K_Q16);
        end
    end

    // restoring divide by flow, one quotient bit per stage
    always_comb begin
        src_rem[0] = '0;
        src_x[0]   = r_prod[PROD_W-1 -: DIV_W];
        for (int k = 1; k < DIV_W; k++) begin
            src_rem[k] = r_drem[k-1];
            src_x[k]   = r_dx[k-1];
        end
        for (int k = 0; k < DIV_W; k++) begin
            logic [FLOW_W:0] sh;
            logic            ge;
            sh = {src_rem[k], src_x[k][DIV_W-1]};
            ge = sh >= {1'b0, i_cfg.flow};
            nxt_rem[k] = ge ? FLOW_W'(sh - {1'b0, i_cfg.flow}) : FLOW_W'(sh);
            nxt_x[k]   = {src_x[k][DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_W; k++) r_dv[k] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_v2;
            for (int k = 1; k < DIV_W; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dit[0] <= r_it2;
            for (int k = 1; k < DIV_W; k++) r_dit[k] <= r_dit[k-1];
            for (int k = 0; k < DIV_W; k++) begin
                r_drem[k] <= nxt_rem[k];
                r_dx[k]   <= nxt_x[k];
            end
        end
    end

    // flow term clamp and the final max
    always_comb begin
        fin    = r_dit[DIV_W-1];
        quo    = r_dx[DIV_W-1];
        ramp_x = {{(TIME_W-RAMP_W){1'b0}}, fin.ramp};
        if (!fin.flw_sel)
            flw = {{(TIME_W-RAMP_W){1'b0}}, T_MIN_US};
        else if (i_cfg.flow == '0)
            flw = TIME_MAX;
        else if (quo < {{(DIV_W-RAMP_W){1'b0}}, T_MIN_US})
            flw = {{(TIME_W-RAMP_W){1'b0}}, T_MIN_US};
        else
            flw = {{(TIME_W-DIV_W){1'b0}}, quo};
        tmax = (flw > ramp_x) ? flw : ramp_x;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_dv[DIV_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_time   <= fin.kill ? '0 : tmax;
            r_len    <= i_cfg.len;
            r_last   <= fin.last;
            r_beyond <= fin.beyond;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_step_time_us   = r_time;
    assign o_profile_length = r_len;
    assign o_last_step      = r_last;
    assign o_beyond_profile = r_beyond;
endmodule
`default_nettype wire
